@@ rtl/assert_macros.svh @@
// Assertion macros shared by the terminal writer RTL.
// Every check is sampled on the rising edge of clk and is off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold on every sampled edge.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/ttw_pkg.sv @@
// ---------------------------------------------------------------------------
// ttw_pkg: shared definitions for the text mode terminal writer
// Screen geometry, field types, request codes, sequencer states and the
// structures passed between the sequencer and the top level.
// ---------------------------------------------------------------------------
package ttw_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int NCELLS = COLS * ROWS;

  localparam int ADDR_W = 11;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [CELL_W-1:0] cell_t;

  localparam logic  REQ_PUT     = 1'b0;
  localparam logic  REQ_READ    = 1'b1;
  localparam char_t CH_NEWLINE  = 8'd10;
  localparam char_t CH_SPACE    = 8'h20;
  localparam char_t RESET_COLOR = 8'd7;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL
  } state_t;

  // One access to the screen memory: write port and read port controls.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    cell_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

  // Result word to be loaded into the output register.
  typedef struct packed {
    logic  load;
    logic  use_ram;
    addr_t cursor;
    row_t  row;
    col_t  col;
  } rsp_ctrl_t;

endpackage

@@ rtl/ttw_req_if.sv @@
// ---------------------------------------------------------------------------
// ttw_req_if: request channel of the terminal writer
// Valid/ready channel carrying one put or read request per word.
// ---------------------------------------------------------------------------
interface ttw_req_if;
  import ttw_pkg::*;

  logic  valid;
  logic  ready;
  logic  req_type;
  char_t char_code;
  addr_t cell_index;

  modport source (output valid, output req_type, output char_code, output cell_index,
                  input ready);
  modport sink (input valid, input req_type, input char_code, input cell_index,
                output ready);
endinterface

@@ rtl/ttw_rsp_if.sv @@
// ---------------------------------------------------------------------------
// ttw_rsp_if: response channel of the terminal writer
// Valid/ready channel carrying one result word per request.
// ---------------------------------------------------------------------------
interface ttw_rsp_if;
  import ttw_pkg::*;

  logic  valid;
  logic  ready;
  cell_t cell_data;
  addr_t cursor_pos;
  row_t  write_row;
  col_t  write_col;

  modport source (output valid, output cell_data, output cursor_pos, output write_row,
                  output write_col, input ready);
  modport sink (input valid, input cell_data, input cursor_pos, input write_row,
                input write_col, output ready);
endinterface

@@ rtl/ttw_screen_ram.sv @@
// ---------------------------------------------------------------------------
// ttw_screen_ram: simple dual port screen memory
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
module ttw_screen_ram #(
  parameter int DEPTH  = 2000,
  parameter int DATA_W = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/ttw_seq.sv @@
// ---------------------------------------------------------------------------
// ttw_seq: terminal writer sequencer
// Holds the write position and the scroll offset of the ring of screen rows,
// drives the screen memory and tells the top level when a result is ready.
// ---------------------------------------------------------------------------
module ttw_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               req_type,
  input  ttw_pkg::char_t     char_code,
  input  ttw_pkg::addr_t     cell_index,
  input  ttw_pkg::char_t     text_color,
  input  logic               slot_free,
  output ttw_pkg::mem_req_t  mem_req,
  output ttw_pkg::rsp_ctrl_t rsp_ctrl
);
  import ttw_pkg::*;

  `include "assert_macros.svh"

  state_t state, state_next;
  row_t   row, row_next;
  col_t   col, col_next;
  addr_t  cursor, cursor_next;
  addr_t  base, base_next;
  addr_t  cnt, cnt_next;
  logic   rd_hit, rd_hit_next;

  logic              accept;
  logic              last_row;
  logic              last_col;
  logic              is_newline;
  logic              idx_hit;
  addr_t             lin_pos;
  addr_t             map_in;
  logic [ADDR_W:0]   phys_sum;
  addr_t             phys;

  assign accept     = req_valid && req_ready;
  assign last_row   = (row == ROW_W'(ROWS - 1));
  assign last_col   = (col == COL_W'(COLS - 1));
  assign is_newline = (char_code == CH_NEWLINE);
  assign idx_hit    = (cell_index < ADDR_W'(NCELLS));
  assign lin_pos    = ADDR_W'(row) * ADDR_W'(COLS) + ADDR_W'(col);

  // Logical cell to memory cell: the top screen row sits at base in the ring.
  assign map_in   = (req_type == REQ_READ) ? cell_index : lin_pos;
  assign phys_sum = {1'b0, map_in} + {1'b0, base};
  assign phys     = (phys_sum >= (ADDR_W + 1)'(NCELLS)) ?
                    ADDR_W'(phys_sum - (ADDR_W + 1)'(NCELLS)) : phys_sum[ADDR_W-1:0];

  // Next state and position.
  always_comb begin
    state_next  = state;
    row_next    = row;
    col_next    = col;
    cursor_next = cursor;
    base_next   = base;
    cnt_next    = cnt;
    rd_hit_next = rd_hit;
    case (state)
      ST_CLEAR: begin
        cnt_next = cnt + 1'b1;
        if (cnt == ADDR_W'(NCELLS - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_type == REQ_READ) begin
            rd_hit_next = idx_hit;
            state_next  = ST_READ;
          end else if (is_newline) begin
            col_next = '0;
            if (last_row) begin
              state_next = ST_SCROLL;
            end else begin
              row_next = row + 1'b1;
            end
          end else begin
            cursor_next = lin_pos + 1'b1;
            if (last_col) begin
              col_next = '0;
              if (last_row) begin
                state_next = ST_SCROLL;
              end else begin
                row_next = row + 1'b1;
              end
            end else begin
              col_next = col + 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      ST_SCROLL: begin
        cnt_next = cnt + 1'b1;
        if (cnt == ADDR_W'(COLS - 1)) begin
          cnt_next   = '0;
          base_next  = (base == ADDR_W'(NCELLS - COLS)) ? '0 : base + ADDR_W'(COLS);
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Memory accesses, handshake and result loading.
  always_comb begin
    req_ready = (state == ST_IDLE) && slot_free;
    mem_req   = '0;
    rsp_ctrl  = '0;
    rsp_ctrl.cursor = cursor_next;
    rsp_ctrl.row    = row_next;
    rsp_ctrl.col    = col_next;
    case (state)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt;
        mem_req.wdata = {RESET_COLOR, CH_SPACE};
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_type == REQ_READ) begin
            mem_req.re    = idx_hit;
            mem_req.raddr = phys;
          end else begin
            mem_req.we    = !is_newline;
            mem_req.waddr = phys;
            mem_req.wdata = {text_color, char_code};
            rsp_ctrl.load = (state_next == ST_IDLE);
          end
        end
      end
      ST_READ: begin
        rsp_ctrl.load    = 1'b1;
        rsp_ctrl.use_ram = rd_hit;
      end
      ST_SCROLL: begin
        // The old top row becomes the new bottom row and is blanked.
        mem_req.we    = 1'b1;
        mem_req.waddr = base + cnt;
        mem_req.wdata = {text_color, CH_SPACE};
        rsp_ctrl.load = (state_next == ST_IDLE);
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      row    <= '0;
      col    <= '0;
      cursor <= '0;
      base   <= '0;
      cnt    <= '0;
      rd_hit <= 1'b0;
    end else begin
      state  <= state_next;
      row    <= row_next;
      col    <= col_next;
      cursor <= cursor_next;
      base   <= base_next;
      cnt    <= cnt_next;
      rd_hit <= rd_hit_next;
    end
  end

  `ASSERT_ALWAYS(a_pos_in_screen, (row < ROW_W'(ROWS)) && (col < COL_W'(COLS)), "write position left the screen")
  `ASSERT_IMPLIES(a_scroll_writes, state == ST_SCROLL, mem_req.we && (mem_req.waddr < ADDR_W'(NCELLS)), "row blanking write missing or out of range")
  `ASSERT_IMPLIES(a_read_after_idle, state == ST_READ, $past(state) == ST_IDLE, "read wait entered from wrong state")
  `ASSERT_IMPLIES(a_base_moves_on_scroll, !$stable(base), $past(state) == ST_SCROLL, "row ring offset changed outside a scroll")

endmodule

@@ rtl/text_mode_terminal_writer_unit.sv @@
// ---------------------------------------------------------------------------
// text_mode_terminal_writer_unit: text console writer with screen memory
// Keeps an 80 by 25 screen of character and attribute cells, writes
// characters at a moving write position and serves cell reads.
// ---------------------------------------------------------------------------
// After reset the unit blanks the screen memory, one cell a cycle, and takes
// no request words until that pass is done; the colour register can be
// written throughout. Every request word gives exactly one response word. A
// put of an ordinary character writes one cell and its response is ready in
// the next cycle; a read passes through a wait state because the screen
// memory has a registered read port; a newline writes no cell. When a
// newline or a wrap at the end of a row falls on the last row the screen
// scrolls, and the response follows once every cell of the row is
// blanked. Scrolling moves no data: the screen rows form a ring in memory,
// the old top row is blanked in the current colour and becomes the bottom
// row, and the ring offset advances by one row. Only one request is in
// flight at a time, so a memory read never meets a write to the same cell.
// The response sits in a single output register, and a new request word is
// taken only when that register is empty or is being emptied in the same
// cycle, so a consumer that holds back its response also holds off the
// request channel.
module text_mode_terminal_writer_unit (
  input  logic           clk,
  input  logic           rst,
  ttw_req_if.sink        req,
  ttw_rsp_if.source      rsp,
  input  logic           cfg_we,
  input  ttw_pkg::char_t cfg_wdata
);
  import ttw_pkg::*;

  `include "assert_macros.svh"

  char_t     text_color;
  mem_req_t  mem_req;
  rsp_ctrl_t rsp_ctrl;
  cell_t     rdata;
  logic      slot_free;

  logic      out_valid;
  cell_t     out_cell;
  addr_t     out_cursor;
  row_t      out_row;
  col_t      out_col;

  // The colour register: attribute of written characters and blanked rows.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (cfg_we) begin
      text_color <= cfg_wdata;
    end
  end

  ttw_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_type   (req.req_type),
    .char_code  (req.char_code),
    .cell_index (req.cell_index),
    .text_color (text_color),
    .slot_free  (slot_free),
    .mem_req    (mem_req),
    .rsp_ctrl   (rsp_ctrl)
  );

  ttw_screen_ram #(
    .DEPTH  (NCELLS),
    .DATA_W (CELL_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  // The output register is free when empty or emptied in this cycle.
  assign slot_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp_ctrl.load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Puts and out-of-range reads return a zero cell.
  always_ff @(posedge clk) begin
    if (rsp_ctrl.load) begin
      out_cell   <= rsp_ctrl.use_ram ? rdata : '0;
      out_cursor <= rsp_ctrl.cursor;
      out_row    <= rsp_ctrl.row;
      out_col    <= rsp_ctrl.col;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.cell_data  = out_cell;
  assign rsp.cursor_pos = out_cursor;
  assign rsp.write_row  = out_row;
  assign rsp.write_col  = out_col;

  `ASSERT_IMPLIES(a_no_overwrite, rsp_ctrl.load, slot_free, "response loaded over an untaken word")
  `ASSERT_IMPLIES(a_no_access_clash, mem_req.we && mem_req.re, 1'b0, "memory read and write in one cycle")
  `ASSERT_IMPLIES(a_read_returns, $past(mem_req.re), rsp_ctrl.load && rsp_ctrl.use_ram, "memory read not returned as a response")

endmodule
